// File: design/texture_tile_swizzle_addresser_assert.svh
// Assertion macros for the tiled texture addresser.
`ifndef TEXTURE_TILE_SWIZZLE_ADDRESSER_ASSERT_SVH
`define TEXTURE_TILE_SWIZZLE_ADDRESSER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TTSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ttsa assertion failed");
`define TTSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ttsa assertion failed");
`else
`define TTSA_ASSERT(lbl, prop)
`define TTSA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: design/ttsa_pkg.sv
// Types and constants shared by the tiled texture addresser.
`timescale 1ns / 1ps
package ttsa_pkg;

  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned DIM_W   = 11;

  localparam logic [3:0] FMT_I4  = 4'd2;
  localparam logic [3:0] FMT_32  = 4'd3;
  localparam logic [3:0] FMT_8_A = 4'd4;
  localparam logic [3:0] FMT_8_B = 4'd6;
  localparam logic [3:0] FMT_8_C = 4'd8;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_SWAP   = 2'd3;

  localparam logic [21:0] GB_OFFSET = 22'h20;

  typedef enum logic [1:0] {
    MODE_32 = 2'd0,
    MODE_16 = 2'd1,
    MODE_8  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [9:0]  texel_x;
    logic [9:0]  texel_y;
    logic [31:0] texel_value;
  } texel_t;

  typedef struct packed {
    logic [21:0] dest_addr;
    logic [15:0] write_data;
    logic [1:0]  byte_count;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [3:0]       texture_format;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             endian_swap;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [21:0] addr0;
    logic [21:0] addr1;
    logic [15:0] data0;
    logic [15:0] data1;
  } pipe_out_t;

endpackage

// File: design/ttsa_pipe.sv
// Three-stage address pipeline: capture, decode and tiles, band product.
`timescale 1ns / 1ps
module ttsa_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttsa_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ttsa_pkg::texel_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ttsa_pkg::pipe_out_t out_o
);
  import ttsa_pkg::*;

  // stage A: captured texel
  logic   a_valid_q;
  texel_t a_data_q;
  logic   a_ready;

  // stage B: decoded
  logic        b_valid_q, b_valid_d, b_ready;
  mode_e       b_mode_q, b_mode_d;
  logic [7:0]  b_band_q;
  logic [8:0]  b_tiles_q, b_tiles_d;
  logic [7:0]  b_xtile_q, b_xtile_d;
  logic [5:0]  b_inner_q, b_inner_d;
  logic [15:0] b_d0_q, b_d0_d, b_d1_q;

  // stage C: band * tiles
  logic        c_valid_q, c_ready;
  mode_e       c_mode_q;
  logic [16:0] c_prod_q;
  logic [7:0]  c_xtile_q;
  logic [5:0]  c_inner_q;
  logic [15:0] c_d0_q, c_d1_q;

  logic [DIM_W-1:0] w_sat, h_sat, w_p3, w_p7;
  logic [16:0]      tile;
  logic [21:0]      addr0;

  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= b_valid_d;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready) a_data_q <= in_data_i;
  end

  // decode
  always_comb begin
    w_sat = (cfg_i.image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.image_width;
    h_sat = (cfg_i.image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_i.image_height;
    w_p3  = w_sat + DIM_W'(3);
    w_p7  = w_sat + DIM_W'(7);

    priority if (cfg_i.texture_format == FMT_32) begin
      b_mode_d = MODE_32;
    end else if (cfg_i.texture_format == FMT_8_A || cfg_i.texture_format == FMT_8_B ||
                 cfg_i.texture_format == FMT_8_C) begin
      b_mode_d = MODE_8;
    end else begin
      b_mode_d = MODE_16;
    end

    b_valid_d = a_valid_q && (cfg_i.texture_format != FMT_I4) &&
                ({1'b0, a_data_q.texel_x} < w_sat) && ({1'b0, a_data_q.texel_y} < h_sat);

    if (b_mode_d == MODE_8) begin
      b_tiles_d = {1'b0, w_p7[10:3]};
      b_xtile_d = {1'b0, a_data_q.texel_x[9:3]};
      b_inner_d = {1'b0, a_data_q.texel_y[1:0], a_data_q.texel_x[2:0]};
    end else begin
      b_tiles_d = w_p3[10:2];
      b_xtile_d = a_data_q.texel_x[9:2];
      b_inner_d = {1'b0, a_data_q.texel_y[1:0], a_data_q.texel_x[1:0], 1'b0};
    end

    unique case (b_mode_d)
      MODE_32: b_d0_d = {a_data_q.texel_value[31:24], a_data_q.texel_value[7:0]};
      MODE_8:  b_d0_d = {8'h00, a_data_q.texel_value[7:0]};
      default: b_d0_d = cfg_i.endian_swap ?
                        {a_data_q.texel_value[7:0], a_data_q.texel_value[15:8]} :
                        a_data_q.texel_value[15:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b_ready) begin
      b_mode_q  <= b_mode_d;
      b_band_q  <= a_data_q.texel_y[9:2];
      b_tiles_q <= b_tiles_d;
      b_xtile_q <= b_xtile_d;
      b_inner_q <= b_inner_d;
      b_d0_q    <= b_d0_d;
      b_d1_q    <= {a_data_q.texel_value[15:8], a_data_q.texel_value[23:16]};
    end
    if (c_ready) begin
      c_mode_q  <= b_mode_q;
      c_prod_q  <= 17'(b_band_q) * 17'(b_tiles_q);
      c_xtile_q <= b_xtile_q;
      c_inner_q <= b_inner_q;
      c_d0_q    <= b_d0_q;
      c_d1_q    <= b_d1_q;
    end
  end

  // tile base plus in-tile offset; offset stays below the tile size
  always_comb begin
    tile  = c_prod_q + 17'(c_xtile_q);
    addr0 = (c_mode_q == MODE_32) ? 22'({tile, 6'b0}) : 22'({tile, 5'b0});
    addr0 = addr0 | 22'(c_inner_q);
  end

  assign out_valid_o = c_valid_q;
  assign out_o.mode  = c_mode_q;
  assign out_o.addr0 = addr0;
  assign out_o.addr1 = addr0 | GB_OFFSET;
  assign out_o.data0 = c_d0_q;
  assign out_o.data1 = c_d1_q;

endmodule

// File: design/texture_tile_swizzle_addresser.sv
// Top level of the tiled texture addresser: registers, pipeline, result stage.
//
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one texel (x, y, value)
// per transfer. Output channel (out_valid_o/out_ready_i/out_data_o) gives the
// byte writes into the tiled buffer: two per texel in 32-bit mode (alpha-red,
// then green-blue 0x20 bytes on), one in 16-bit and 8-bit modes, none for the
// 4-bit format or for texels outside the image.
// A texel passes the capture, decode and band-times-tiles product registers
// and then the result register before its result is offered.
// In 16-bit and 8-bit modes one texel per cycle is taken while the receiver
// is ready; in 32-bit mode the single result register emits both halves of a
// texel before the next. Dropped texels pass as bubbles and write nothing.
// Reset clears all valid bits and loads the registers with format 32-bit,
// 1024 x 1024, no byte swap. When the receiver stalls, the result register
// holds and the pipeline fills; in_ready_o falls once every stage is full, and
// nothing is lost or repeated. The user must write the registers over the APB
// port only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "texture_tile_swizzle_addresser_assert.svh"
module texture_tile_swizzle_addresser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttsa_pkg::texel_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ttsa_pkg::result_t out_data_o
);
  import ttsa_pkg::*;

  cfg_t cfg_q;
  logic reg_wr;

  logic      pipe_valid, pipe_ready;
  pipe_out_t pipe_out;

  logic        o_valid_q, o_phase_q;
  mode_e       o_mode_q;
  logic [21:0] o_addr0_q, o_addr1_q;
  logic [15:0] o_d0_q, o_d1_q;
  logic        o_last, out_xfer;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.texture_format <= FMT_32;
      cfg_q.image_width    <= DIM_W'(MAX_DIM);
      cfg_q.image_height   <= DIM_W'(MAX_DIM);
      cfg_q.endian_swap    <= 1'b0;
    end else if (reg_wr) begin
      unique case (paddr[3:2])
        REG_FORMAT: cfg_q.texture_format <= pwdata[3:0];
        REG_WIDTH:  cfg_q.image_width    <= pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_q.image_height   <= pwdata[DIM_W-1:0];
        REG_SWAP:   cfg_q.endian_swap    <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FORMAT: prdata = 32'(cfg_q.texture_format);
      REG_WIDTH:  prdata = 32'(cfg_q.image_width);
      REG_HEIGHT: prdata = 32'(cfg_q.image_height);
      REG_SWAP:   prdata = 32'(cfg_q.endian_swap);
      default:    prdata = '0;
    endcase
  end

  ttsa_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (pipe_valid),
    .out_ready_i (pipe_ready),
    .out_o       (pipe_out)
  );

  // result stage: second half of a 32-bit texel follows the first
  assign o_last     = (o_mode_q != MODE_32) || o_phase_q;
  assign out_xfer   = o_valid_q && out_ready_i;
  assign pipe_ready = !o_valid_q || (out_ready_i && o_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      o_phase_q <= 1'b0;
    end else if (pipe_ready) begin
      o_valid_q <= pipe_valid;
      o_phase_q <= 1'b0;
    end else if (out_xfer) begin
      o_phase_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_ready) begin
      o_mode_q  <= pipe_out.mode;
      o_addr0_q <= pipe_out.addr0;
      o_addr1_q <= pipe_out.addr1;
      o_d0_q    <= pipe_out.data0;
      o_d1_q    <= pipe_out.data1;
    end
  end

  assign out_valid_o            = o_valid_q;
  assign out_data_o.dest_addr   = o_phase_q ? o_addr1_q : o_addr0_q;
  assign out_data_o.write_data  = o_phase_q ? o_d1_q : o_d0_q;
  assign out_data_o.byte_count  = (o_mode_q == MODE_8) ? 2'd1 : 2'd2;
  assign out_data_o.last_of_run = o_last;

  `TTSA_ASSERT(a_single_byte_last, !(out_valid_o && out_data_o.byte_count == 2'd1) || out_data_o.last_of_run)
  `TTSA_ASSERT(a_phase_only_32, !o_phase_q || !o_valid_q || o_mode_q == MODE_32)
  `TTSA_ASSERT_NEXT(a_second_half_follows, out_xfer && !o_last, out_valid_o && o_phase_q)
  `TTSA_ASSERT_NEXT(a_gb_offset, out_xfer && !o_last, out_data_o.dest_addr == 22'($past(out_data_o.dest_addr) + GB_OFFSET))

endmodule
